// File: hw/rtl/bba_pkg.sv
// Shared status codes and fixed constants of the buddy block allocator.
`default_nettype none

package bba_pkg;

    // Bytes of the size header written in front of every allocated area.
    localparam int unsigned HEADER_BYTES = 4;

    // Width of the request field and of the rounded byte total.
    localparam int unsigned REQ_W   = 16;
    localparam int unsigned TOTAL_W = REQ_W + 1;
    // Width of the rounded word count of a request, including the header.
    localparam int unsigned WORDS_W = TOTAL_W - 2;
    // Width of the order needed for the largest word count.
    localparam int unsigned REQ_ORD_W = 4;

    // Result field widths.
    localparam int unsigned AREA_W  = 12;
    localparam int unsigned ORDER_W = 4;

    // Heap word width.
    localparam int unsigned WORD_W = 32;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO_SIZE = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_NO_BLOCK  = 2'd3
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/buddy_block_allocate_unit.sv
// Buddy block allocator, allocation side: free lists and heap in synchronous memories.
`default_nettype none

// Usage
// -----
// Input channel (i_valid / o_ready) carries one allocation request in bytes.
// Output channel (o_valid / i_ready) returns one result per request: status,
// word offset of the usable area (one past the header) and the block order.
// One request is worked at a time. After acceptance the block scans the
// free-list heads one order a cycle from the needed order upward, pops the
// found block (one heap read), then splits it down one order a cycle, each
// split writing the buddy's link into the heap and the new list head. A last
// cycle writes the size header and a further one loads the output register.
// A rejected request skips the scan and goes straight to the result state;
// the header keeps the needed order at 1 or more. The free-list memory port
// (one read per cycle) sets the scan pace and the heap port (one access
// per cycle) sets the split pace. o_ready rises in the cycle the result
// is loaded. A stalled receiver holds the result in the output register;
// a finished result waits for it before the next one.
// Reset leaves the heap as one free block of order MAX_ORDER at offset 0:
// free-list heads read as their reset value until first written, and heap
// word 0 reads as a null link until first written. No clearing pass is run.

module buddy_block_allocate_unit #(
    parameter int unsigned HEAP_WORDS = 4096,
    parameter int unsigned MAX_ORDER  = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [bba_pkg::REQ_W-1:0]            i_request_bytes,
    // result channel
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [1:0]                                o_status,
    output logic [bba_pkg::AREA_W-1:0]                o_area_offset,
    output logic [bba_pkg::ORDER_W-1:0]               o_block_order
);

    // Heap address width, order index width, buddy width and link width.
    localparam int unsigned AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
    localparam int unsigned OW = $clog2(MAX_ORDER + 1);
    localparam int unsigned BW = (AW > MAX_ORDER) ? AW : MAX_ORDER;
    localparam int unsigned LW = BW + 1;
    localparam int unsigned FH_DEPTH = MAX_ORDER + 1;

    localparam logic [OW-1:0] MaxOrd   = OW'(MAX_ORDER);
    localparam logic [LW-1:0] HeapLink = LW'(HEAP_WORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_SPLIT,
        S_FINISH,
        S_RESULT
    } t_state;

    t_state r_state;

    // Request decode
    logic [bba_pkg::TOTAL_W-1:0]   req_total;
    logic [bba_pkg::TOTAL_W-1:0]   req_round;
    logic [bba_pkg::WORDS_W-1:0]   req_words;
    logic [bba_pkg::REQ_ORD_W-1:0] req_order;
    logic                          req_zero;
    logic                          req_large;

    always_comb begin
        req_total = {1'b0, i_request_bytes} + bba_pkg::TOTAL_W'(bba_pkg::HEADER_BYTES);
        req_round = {1'b0, i_request_bytes} + bba_pkg::TOTAL_W'(bba_pkg::HEADER_BYTES + 3);
        req_words = req_round[bba_pkg::TOTAL_W-1:2];
        req_zero  = (i_request_bytes == '0);
        // Smallest order whose block holds the word count.
        req_order = '0;
        for (int i = 0; i < bba_pkg::WORDS_W; i++) begin
            if ((32'd1 << i) < 32'(req_words)) begin
                req_order = bba_pkg::REQ_ORD_W'(i + 1);
            end
        end
        req_large = (32'(req_words) > 32'(HEAP_WORDS)) ||
                    (32'(req_order) > 32'(MAX_ORDER));
    end

    // Working registers
    logic [bba_pkg::TOTAL_W-1:0] r_total;
    logic [OW-1:0]               r_order;
    logic [OW-1:0]               r_slot;
    logic [AW-1:0]               r_off;
    bba_pkg::t_status            r_status;
    logic                        r_w0_written;

    // Free-list head memory with per-entry valid bits
    logic [LW-1:0]       fh_mem [FH_DEPTH];
    logic [MAX_ORDER:0]  r_fh_valid;
    logic [LW-1:0]       r_fh_rdata;
    logic                r_fh_rvld;
    logic [LW-1:0]       r_fh_rrst;
    logic [OW-1:0]       fh_raddr;
    logic                fh_we;
    logic [OW-1:0]       fh_waddr;
    logic [LW-1:0]       fh_wdata;
    logic [LW-1:0]       fh_link;
    logic                fh_link_ok;

    // Heap memory
    logic [bba_pkg::WORD_W-1:0] hp_mem [HEAP_WORDS];
    logic [bba_pkg::WORD_W-1:0] r_hp_rdata;
    logic                       r_hp_zero;
    logic                       hp_re;
    logic [AW-1:0]              hp_raddr;
    logic                       hp_we;
    logic [AW-1:0]              hp_waddr;
    logic [bba_pkg::WORD_W-1:0] hp_wdata;

    // Split datapath
    logic [BW-1:0] buddy;
    logic [LW-1:0] buddy_link;
    logic          buddy_in_heap;
    logic [LW-1:0] next_link;
    logic          out_free;

    always_comb begin
        // head read back: an entry never written holds its reset value
        fh_link    = r_fh_rvld ? r_fh_rdata : r_fh_rrst;
        fh_link_ok = (fh_link != '0) && (fh_link <= HeapLink);
        next_link  = r_hp_zero ? '0 : r_hp_rdata[LW-1:0];
        buddy      = BW'(r_off) ^ (BW'(1) << (r_slot - OW'(1)));
        buddy_link = LW'(buddy) + LW'(1);
        buddy_in_heap = (32'(buddy) < 32'(HEAP_WORDS));
        out_free   = !o_valid || i_ready;
    end

    // Memory port control
    always_comb begin
        fh_raddr = r_slot;
        fh_we    = 1'b0;
        fh_waddr = r_slot;
        fh_wdata = next_link;
        hp_re    = 1'b0;
        hp_raddr = AW'(fh_link - LW'(1));
        hp_we    = 1'b0;
        hp_waddr = r_off;
        hp_wdata = bba_pkg::WORD_W'(r_total);
        unique case (r_state)
            S_IDLE: begin
                fh_raddr = req_large ? MaxOrd : OW'(req_order);
            end
            S_SCAN: begin
                if (fh_link_ok) begin
                    hp_re = 1'b1;
                end else if (r_slot != MaxOrd) begin
                    fh_raddr = r_slot + OW'(1);
                end
            end
            S_POP: begin
                // pop the head and fetch the next lower head for the first split
                fh_we    = 1'b1;
                fh_waddr = r_slot;
                fh_wdata = next_link;
                if (r_slot > r_order) begin
                    fh_raddr = r_slot - OW'(1);
                end
            end
            S_SPLIT: begin
                // push the upper buddy onto the next lower list
                fh_we    = 1'b1;
                fh_waddr = r_slot - OW'(1);
                fh_wdata = buddy_link;
                hp_we    = buddy_in_heap;
                hp_waddr = AW'(buddy);
                hp_wdata = bba_pkg::WORD_W'(fh_link);
                if ((r_slot - OW'(1)) > r_order) begin
                    fh_raddr = r_slot - OW'(2);
                end
            end
            S_FINISH: begin
                // size header into the block's first word
                hp_we    = 1'b1;
                hp_waddr = r_off;
                hp_wdata = bba_pkg::WORD_W'(r_total);
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // Free-list head memory
    always_ff @(posedge i_clk) begin
        if (fh_we) begin
            fh_mem[fh_waddr] <= fh_wdata;
        end
        r_fh_rdata <= fh_mem[fh_raddr];
        r_fh_rrst  <= (fh_raddr == MaxOrd) ? LW'(1) : '0;
    end

    // Heap memory
    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            hp_mem[hp_waddr] <= hp_wdata;
        end
        if (hp_re) begin
            r_hp_rdata <= hp_mem[hp_raddr];
        end
    end

    // Control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_valid      <= 1'b0;
            r_w0_written <= 1'b0;
            r_fh_valid   <= '0;
            r_fh_rvld    <= 1'b0;
            r_hp_zero    <= 1'b0;
        end else begin
            r_fh_rvld <= r_fh_valid[fh_raddr];
            if (hp_re) begin
                r_hp_zero <= (hp_raddr == '0) && !r_w0_written;
            end
            if (fh_we) begin
                r_fh_valid[fh_waddr] <= 1'b1;
            end
            if (hp_we && (hp_waddr == '0)) begin
                r_w0_written <= 1'b1;
            end
            // drop valid once taken, unless the next result loads in its place
            if (o_valid && i_ready && (r_state != S_RESULT)) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_total <= req_total;
                        r_order <= req_large ? MaxOrd : OW'(req_order);
                        r_slot  <= req_large ? MaxOrd : OW'(req_order);
                        priority if (req_zero) begin
                            r_status <= bba_pkg::STAT_ZERO_SIZE;
                            r_state  <= S_RESULT;
                        end else if (req_large) begin
                            r_status <= bba_pkg::STAT_TOO_LARGE;
                            r_state  <= S_RESULT;
                        end else begin
                            r_status <= bba_pkg::STAT_OK;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (fh_link_ok) begin
                        r_off   <= AW'(fh_link - LW'(1));
                        r_state <= S_POP;
                    end else if (r_slot == MaxOrd) begin
                        r_status <= bba_pkg::STAT_NO_BLOCK;
                        r_state  <= S_RESULT;
                    end else begin
                        r_slot <= r_slot + OW'(1);
                    end
                end
                S_POP: begin
                    r_state <= (r_slot > r_order) ? S_SPLIT : S_FINISH;
                end
                S_SPLIT: begin
                    r_slot <= r_slot - OW'(1);
                    if ((r_slot - OW'(1)) == r_order) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        o_valid  <= 1'b1;
                        o_status <= r_status;
                        if (r_status == bba_pkg::STAT_OK) begin
                            o_area_offset <= bba_pkg::AREA_W'(32'(r_off) + 32'd1);
                            o_block_order <= bba_pkg::ORDER_W'(32'(r_order));
                        end else begin
                            o_area_offset <= '0;
                            o_block_order <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    // An error result carries no area and no order.
    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bba_pkg::STAT_OK)) |->
            ((o_area_offset == '0) && (o_block_order == '0)))
        else $error("error result with non-zero fields");

    // Splitting only ever runs above the needed order.
    a_split_above_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_slot > r_order))
        else $error("split below needed order");

    // The scan never walks past the top order.
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_POP)) |-> (r_slot <= MaxOrd))
        else $error("free-list index beyond top order");

    // A new result appears only from the result state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_RESULT))
        else $error("result loaded outside result state");
`endif

endmodule

`default_nettype wire

// File: sim/tb_buddy_block_allocate_unit.sv
// Testbench for the buddy block allocator: directed and random requests, self-checking.
`timescale 1ns / 100ps

module tb_buddy_block_allocate_unit;

    localparam int unsigned HEAP_SIZE_WORDS = 4096;
    localparam int unsigned TOP_ORDER       = 12;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned MAX_IDLE        = 14;
    // Settle time at the end of the run: the worst accept-to-result time plus some slack.
    localparam int unsigned SETTLE_CYCLES   = 2 * TOP_ORDER + 20;

    typedef struct packed {
        bba_pkg::t_status                    status;
        logic [bba_pkg::AREA_W-1:0]          area;
        logic [bba_pkg::ORDER_W-1:0]         order;
    } t_alloc_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [bba_pkg::REQ_W-1:0]     i_request_bytes;
    logic                          o_valid;
    logic                          i_ready;
    logic [1:0]                    o_status;
    logic [bba_pkg::AREA_W-1:0]    o_area_offset;
    logic [bba_pkg::ORDER_W-1:0]   o_block_order;

    // Shadow allocator state: free-list head links (offset + 1, 0 is empty)
    // and heap words, of which only the link words matter here.
    int unsigned free_link [TOP_ORDER+1];
    int unsigned heap_mem  [HEAP_SIZE_WORDS];

    t_alloc_result pending_allocs[$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_wait     = 0;   // per-result stall of the receiver
    int unsigned rx_hold     = 0;   // long hold-off, counted down by the receiver
    bit          burst_mode  = 1'b0; // no idling on either side while set

    buddy_block_allocate_unit #(
        .HEAP_WORDS (HEAP_SIZE_WORDS),
        .MAX_ORDER  (TOP_ORDER)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_request_bytes (i_request_bytes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_area_offset   (o_area_offset),
        .o_block_order   (o_block_order)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the result of one allocation request and update the shadow
    // free lists: pop the lowest non-empty order at or above the needed one,
    // then split down, pushing every upper buddy onto the next lower list.
    function automatic t_alloc_result predict_allocation(
        input logic [bba_pkg::REQ_W-1:0] bytes
    );
        t_alloc_result res;
        int unsigned   total;
        int unsigned   words;
        int unsigned   need;
        int unsigned   slot;
        int unsigned   off;
        int unsigned   buddy;
        res = '{status: bba_pkg::STAT_OK, area: '0, order: '0};
        if (bytes == 0) begin
            res.status = bba_pkg::STAT_ZERO_SIZE;
            return res;
        end
        total = bytes + bba_pkg::HEADER_BYTES;
        words = (total + 3) >> 2;
        if (words > HEAP_SIZE_WORDS) begin
            res.status = bba_pkg::STAT_TOO_LARGE;
            return res;
        end
        need = 0;
        while (need < 31 && (1 << need) < words)
            need++;
        if (need > TOP_ORDER) begin
            res.status = bba_pkg::STAT_TOO_LARGE;
            return res;
        end
        // A link beyond the heap counts as an empty list.
        slot = need;
        while (slot <= TOP_ORDER &&
               (free_link[slot] == 0 || free_link[slot] > HEAP_SIZE_WORDS))
            slot++;
        if (slot > TOP_ORDER) begin
            res.status = bba_pkg::STAT_NO_BLOCK;
            return res;
        end
        off             = free_link[slot] - 1;
        free_link[slot] = heap_mem[off];
        while (slot > need) begin
            slot--;
            buddy = off ^ (1 << slot);
            if (buddy < HEAP_SIZE_WORDS)
                heap_mem[buddy] = free_link[slot];
            free_link[slot] = buddy + 1;
        end
        heap_mem[off] = total;
        res.area  = bba_pkg::AREA_W'(off + 1);
        res.order = bba_pkg::ORDER_W'(need);
        return res;
    endfunction

    // Offer one request after a random gap, hold it until accepted, then log
    // its expected result. Valid stays high afterwards so that a following
    // request with no gap goes out back to back.
    task automatic send_request(input logic [bba_pkg::REQ_W-1:0] bytes);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_request_bytes <= bytes;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_allocs.push_back(predict_allocation(bytes));
    endtask

    // Drop valid and hold off until every outstanding result is back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge i_clk);
    endtask

    // Smallest request byte count landing in a block of the given order.
    function automatic logic [bba_pkg::REQ_W-1:0] order_low_bytes(input int unsigned ord);
        return bba_pkg::REQ_W'((2 << ord) - 3);
    endfunction

    // Largest request byte count landing in a block of the given order.
    function automatic logic [bba_pkg::REQ_W-1:0] order_high_bytes(input int unsigned ord);
        return bba_pkg::REQ_W'((4 << ord) - 4);
    endfunction

    // Zero size and oversize requests, including all bits of the field set.
    task automatic test_rejected_sizes();
        send_request(16'd0);
        send_request(16'hFFFF);
        send_request(16'h8000);
        send_request(16'd16381);
        send_request(16'd16384);
        wait_results_drained();
    endtask

    // First allocation splits the whole heap down; then walk the rounding
    // edges of each small order, ask for the whole heap (now refused), and
    // take the remaining half-heap block.
    task automatic test_order_boundaries();
        send_request(16'd1);
        for (int unsigned ord = 1; ord <= 7; ord++) begin
            send_request(order_high_bytes(ord));
            send_request(order_high_bytes(ord) + 16'd1);
        end
        send_request(order_high_bytes(TOP_ORDER));
        send_request(order_low_bytes(TOP_ORDER));
        send_request(order_high_bytes(TOP_ORDER - 1));
        send_request(order_high_bytes(TOP_ORDER - 1));
        wait_results_drained();
    endtask

    // Starve the result side for a long stretch while requests keep coming,
    // so the block backs up and stalls its request side.
    task automatic test_receiver_stall();
        @(posedge i_clk);
        rx_hold    = 300;
        burst_mode = 1'b1;
        for (int unsigned n = 0; n < 12; n++)
            send_request(order_high_bytes($urandom_range(1, 3)));
        burst_mode = 1'b0;
        wait_results_drained();
    endtask

    // Mostly small blocks so the free lists see plenty of pops and splits,
    // a few medium ones, and some raw noise across the whole field.
    task automatic test_random_mix(input int unsigned count);
        int unsigned               pick;
        int unsigned               ord;
        logic [bba_pkg::REQ_W-1:0] bytes;
        for (int unsigned n = 0; n < count; n++) begin
            // Alternate stretches with and without idling.
            if (n % 80 == 0)
                burst_mode = 1'b1;
            else if (n % 80 == 25)
                burst_mode = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                ord   = $urandom_range(1, 4);
                bytes = bba_pkg::REQ_W'($urandom_range(order_low_bytes(ord),
                                                       order_high_bytes(ord)));
            end else if (pick < 90) begin
                ord   = $urandom_range(5, 8);
                bytes = bba_pkg::REQ_W'($urandom_range(order_low_bytes(ord),
                                                       order_high_bytes(ord)));
            end else begin
                bytes = bba_pkg::REQ_W'($urandom_range(0, 65535));
            end
            send_request(bytes);
            if (n % 200 == 199)
                wait_results_drained();
        end
        burst_mode = 1'b0;
        wait_results_drained();
    endtask

    // Use up every free block, then check that each order is refused.
    task automatic test_exhausted_heap();
        bit any_free;
        any_free = 1'b1;
        while (any_free) begin
            any_free = 1'b0;
            for (int unsigned ord = 0; ord <= TOP_ORDER; ord++)
                if (free_link[ord] != 0 && free_link[ord] <= HEAP_SIZE_WORDS)
                    any_free = 1'b1;
            if (any_free)
                send_request(order_low_bytes(1));
        end
        for (int unsigned ord = 1; ord <= TOP_ORDER; ord++)
            send_request(order_low_bytes(ord));
        wait_results_drained();
    endtask

    // Receiver: hold ready low through a long hold-off or a per-result stall.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold--;
        end else if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare every result taken against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_allocs.size() == 0) begin
                $display("%0t: unexpected result: status %0d area %0d order %0d",
                         $time, o_status, o_area_offset, o_block_order);
                fail_count++;
            end else begin
                want = pending_allocs.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_area_offset !== want.area) begin
                    $display("%0t: area offset mismatch: expected %0d, got %0d",
                             $time, want.area, o_area_offset);
                    fail_count++;
                end
                if (o_block_order !== want.order) begin
                    $display("%0t: block order mismatch: expected %0d, got %0d",
                             $time, want.order, o_block_order);
                    fail_count++;
                end
            end
            rx_wait = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** buddy_block_allocate_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_request_bytes = '0;
        // Shadow state at reset: one free block of the top order at offset 0.
        foreach (free_link[k])
            free_link[k] = 0;
        foreach (heap_mem[k])
            heap_mem[k] = 0;
        free_link[TOP_ORDER] = 1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rejected_sizes();
        test_order_boundaries();
        test_receiver_stall();
        test_random_mix(640);
        test_exhausted_heap();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_allocs.size() == 0) begin
            $display("** buddy_block_allocate_unit: PASSED **");
        end else begin
            $display("** buddy_block_allocate_unit: FAILED **");
        end
        $finish;
    end

endmodule
